FILE: hdl/utf8_ascii_fold_core_assert.svh
// Assertion macros shared by the UTF-8 folder RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef UTF8_ASCII_FOLD_CORE_ASSERT_SVH
`define UTF8_ASCII_FOLD_CORE_ASSERT_SVH

// Same-cycle implication, checked while reset is low.
`define UAF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uaf assertion failed");

// Next-cycle implication, checked while reset is low.
`define UAF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uaf assertion failed");

`endif

FILE: hdl/uaf_pkg.sv
// Package for the UTF-8 to ASCII folder: result type, reset constant and fold table.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package uaf_pkg;

  localparam logic [15:0] MAX_CHARS_RESET = 16'd255;

  typedef struct packed {
    logic        valid;
    logic [6:0]  ch;
    logic        eos;
    logic [15:0] count;
  } uaf_result_t;

  function automatic logic [6:0] fold_point(input logic [20:0] cp);
    logic [6:0] c;
    c = 7'h00;
    if (cp < 21'h80) begin
      c = cp[6:0];
    end else if (cp inside {[21'hE0:21'hE5]}) begin
      c = 7'h61;
    end else if (cp inside {[21'hE8:21'hEB]}) begin
      c = 7'h65;
    end else if (cp inside {[21'hEC:21'hEF]}) begin
      c = 7'h69;
    end else if (cp inside {[21'hF2:21'hF6]}) begin
      c = 7'h6F;
    end else if (cp inside {[21'hF9:21'hFC]}) begin
      c = 7'h75;
    end else if (cp inside {21'hFD, 21'hFF}) begin
      c = 7'h79;
    end else if (cp == 21'hE7) begin
      c = 7'h63;
    end else if (cp == 21'hF1) begin
      c = 7'h6E;
    end else if (cp inside {[21'hC0:21'hC5]}) begin
      c = 7'h41;
    end else if (cp inside {[21'hC8:21'hCB]}) begin
      c = 7'h45;
    end else if (cp inside {[21'hCC:21'hCF]}) begin
      c = 7'h49;
    end else if (cp inside {[21'hD2:21'hD6]}) begin
      c = 7'h4F;
    end else if (cp inside {[21'hD9:21'hDC]}) begin
      c = 7'h55;
    end else if (cp == 21'hDD) begin
      c = 7'h59;
    end else if (cp == 21'hC7) begin
      c = 7'h43;
    end else if (cp == 21'hD1) begin
      c = 7'h4E;
    end else if (cp inside {[21'h2018:21'h201A]}) begin
      c = 7'h27;
    end else if (cp inside {[21'h201C:21'h201E]}) begin
      c = 7'h22;
    end else if (cp inside {21'h2013, 21'h2014, 21'h2212}) begin
      c = 7'h2D;
    end else if (cp == 21'h2026) begin
      c = 7'h2E;
    end else if (cp == 21'h00A0) begin
      c = 7'h20;
    end
    return c;
  endfunction

endpackage

FILE: hdl/uaf_decode.sv
// Sequence decoder with running string state, output limit and fold to ASCII.
// Depends on uaf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "utf8_ascii_fold_core_assert.svh"

module uaf_decode
  import uaf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [7:0]  in_byte,
  input  logic [15:0] max_chars,
  output uaf_result_t res
);

  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [20:0] partial_point, partial_point_next;
  logic [15:0] written_count, written_count_next;
  logic        silenced, silenced_next;

  logic        try_deliver;
  logic [20:0] cand_point;
  logic [6:0]  folded;
  logic [20:0] shifted;
  logic [1:0]  pending_less;

  assign shifted      = {partial_point[14:0], in_byte[5:0]};
  assign pending_less = bytes_pending - 2'd1;
  assign folded       = fold_point(cand_point);

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_point_next = partial_point;
    written_count_next = written_count;
    silenced_next      = silenced;
    try_deliver        = 1'b0;
    cand_point         = {13'd0, in_byte};
    res                = '0;

    if (in_byte == 8'h00) begin
      res.valid          = 1'b1;
      res.eos            = 1'b1;
      res.count          = written_count;
      bytes_pending_next = 2'd0;
      partial_point_next = 21'd0;
      written_count_next = 16'd0;
      silenced_next      = 1'b0;
    end else if (bytes_pending != 2'd0 && in_byte[7:6] == 2'b10) begin
      partial_point_next = shifted;
      bytes_pending_next = pending_less;
      cand_point         = shifted;
      try_deliver        = (pending_less == 2'd0);
    end else begin
      bytes_pending_next = 2'd0;
      partial_point_next = 21'd0;
      if (!in_byte[7]) begin
        try_deliver = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        bytes_pending_next = 2'd1;
        partial_point_next = {16'd0, in_byte[4:0]};
      end else if (in_byte[7:4] == 4'b1110) begin
        bytes_pending_next = 2'd2;
        partial_point_next = {17'd0, in_byte[3:0]};
      end else if (in_byte[7:3] == 5'b11110) begin
        bytes_pending_next = 2'd3;
        partial_point_next = {18'd0, in_byte[2:0]};
      end
    end

    if (try_deliver && !silenced) begin
      if (written_count >= max_chars || cand_point == 21'd0) begin
        silenced_next = 1'b1;
      end else if (folded != 7'h00) begin
        written_count_next = written_count + 16'd1;
        res.valid          = 1'b1;
        res.ch             = folded;
      end
    end

    if (!fire) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_point <= 21'd0;
      written_count <= 16'd0;
      silenced      <= 1'b0;
    end else if (fire) begin
      bytes_pending <= bytes_pending_next;
      partial_point <= partial_point_next;
      written_count <= written_count_next;
      silenced      <= silenced_next;
    end
  end

  `UAF_ASSERT_NEXT(a_eos_clears, clk, rst, fire && in_byte == 8'h00,
    written_count == 16'd0 && bytes_pending == 2'd0 && !silenced)
  `UAF_ASSERT_NOW(a_silent_no_char, clk, rst, silenced && res.valid, res.eos)

endmodule

FILE: hdl/uaf_out_stage.sv
// Result register between the decoder and the downstream side.
// Depends on uaf_pkg for the result type.
`timescale 1ns / 1ps

module uaf_out_stage
  import uaf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  uaf_result_t res,
  output logic        advance,
  output logic        dst_valid,
  input  logic        dst_stall,
  output logic [6:0]  out_char,
  output logic        end_of_string,
  output logic [15:0] char_count
);

  assign advance = !dst_valid || !dst_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (advance) begin
      dst_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_char      <= res.ch;
      end_of_string <= res.eos;
      char_count    <= res.count;
    end
  end

endmodule

FILE: hdl/utf8_ascii_fold_core.sv
// A byte is registered in the input stage, decoded combinationally, and its result is registered in the output stage.
// Throughput: one byte per cycle unless dst_stall holds a valid result in the output stage.
// A byte that yields no result still passes through the decode stage.
// Reset clears the decoder state and both valid flags, and sets max_chars to 255.
// Depends on uaf_pkg, uaf_decode, uaf_out_stage and the assertion macro header.
`timescale 1ns / 1ps
`include "utf8_ascii_fold_core_assert.svh"

module utf8_ascii_fold_core
  import uaf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [7:0]  in_byte,
  output logic        dst_valid,
  input  logic        dst_stall,
  output logic [6:0]  out_char,
  output logic        end_of_string,
  output logic [15:0] char_count
);

  logic [15:0] max_chars;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        advance;
  logic        fire;
  uaf_result_t res;

  assign cfg_ready = 1'b1;
  assign fire      = s1_valid && advance;
  assign src_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= MAX_CHARS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_chars <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!src_stall) begin
      s1_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!src_stall && src_valid) begin
      s1_byte <= in_byte;
    end
  end

  uaf_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .in_byte   (s1_byte),
    .max_chars (max_chars),
    .res       (res)
  );

  uaf_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .res           (res),
    .advance       (advance),
    .dst_valid     (dst_valid),
    .dst_stall     (dst_stall),
    .out_char      (out_char),
    .end_of_string (end_of_string),
    .char_count    (char_count)
  );

  `UAF_ASSERT_NOW(a_eos_zero_char, clk, rst, dst_valid && end_of_string, out_char == 7'h00)
  `UAF_ASSERT_NOW(a_char_fields, clk, rst, dst_valid && !end_of_string,
    out_char != 7'h00 && char_count == 16'd0)
  `UAF_ASSERT_NEXT(a_held_byte_kept, clk, rst, s1_valid && src_stall,
    s1_valid && s1_byte == $past(s1_byte))

endmodule
